@@ rtl/thread_queue_with_id_search_defines.svh @@
// Assertion macros shared by the thread queue RTL
`ifndef THREAD_QUEUE_WITH_ID_SEARCH_DEFINES_SVH
`define THREAD_QUEUE_WITH_ID_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TQ_ASSERT(label, clk, rst_n, prop, msg)
`define TQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/tq_pkg.sv @@
// Package: types, codes and sizes for the thread queue
`default_nettype none
package tq_pkg;
  localparam int unsigned Capacity = 16;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned LinkW    = SlotW + 1;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam logic [LinkW-1:0] NullLink = LinkW'(Capacity);

  localparam logic [2:0] OpPut    = 3'd0;
  localparam logic [2:0] OpGet    = 3'd1;
  localparam logic [2:0] OpPeek   = 3'd2;
  localparam logic [2:0] OpFind   = 3'd3;
  localparam logic [2:0] OpUnlink = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StBadSlot  = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic             latch;     // capture input transaction
    logic             do_put;
    logic             do_detach; // detach slot held in cur
    logic             load_head; // cur <= head
    logic             step;      // cur <= next[cur]
    logic             cur_unl;   // cur <= unlink slot
    logic             hit_save;  // result ref <= ref[cur]
    logic [2:0]       status;
    logic             set_stat;
    logic             fire;      // drive result strobe
  } tq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       cur_null;
    logic       id_match;
    logic       slot_used;
  } tq_stat_t;
endpackage
`default_nettype wire

@@ rtl/tq_ctrl.sv @@
// Controller: sequences one queue operation at a time
`default_nettype none
`include "thread_queue_with_id_search_defines.svh"
module tq_ctrl import tq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  tq_stat_t      stat_i,
  output tq_cmd_t       cmd_o
);
  typedef enum logic [1:0] {Idle, Decode, Walk, Done} state_e;
  state_e state_q, state_d;
  logic [SlotW:0] steps_q, steps_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    steps_d = steps_q;
    cmd_o   = '0;
    case (state_q)
      Idle: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = Decode;
        end
      end
      Decode: begin
        state_d = Done;
        cmd_o.set_stat = 1'b1;
        cmd_o.status = StOk;
        case (stat_i.op)
          OpPut: begin
            if (stat_i.full) cmd_o.status = StFull;
            else cmd_o.do_put = 1'b1;
          end
          OpGet, OpPeek: begin
            // empty queue: cur is stale, so skip the walk state entirely
            if (stat_i.empty) cmd_o.status = StEmpty;
            else begin
              cmd_o.load_head = 1'b1;
              state_d = Walk;
            end
          end
          OpFind: begin
            cmd_o.status = StNotFound;
            cmd_o.load_head = 1'b1;
            steps_d = '0;
            state_d = Walk;
          end
          OpUnlink: begin
            if (!stat_i.slot_used) cmd_o.status = StBadSlot;
            else begin
              cmd_o.cur_unl = 1'b1;
              state_d = Walk;
            end
          end
          default: ;
        endcase
      end
      Walk: begin
        state_d = Done;
        case (stat_i.op)
          OpGet: begin
            if (!stat_i.cur_null) begin
              cmd_o.hit_save = 1'b1;
              cmd_o.do_detach = 1'b1;
            end
          end
          OpPeek: cmd_o.hit_save = !stat_i.cur_null;
          OpUnlink: cmd_o.do_detach = 1'b1;
          OpFind: begin
            if (!stat_i.cur_null && steps_q < (SlotW+1)'(Capacity)) begin
              if (stat_i.id_match) begin
                cmd_o.hit_save = 1'b1;
                cmd_o.set_stat = 1'b1;
                cmd_o.status = StOk;
              end else begin
                cmd_o.step = 1'b1;
                steps_d = steps_q + 1'b1;
                state_d = Walk;
              end
            end
          end
          default: ;
        endcase
      end
      Done: begin
        cmd_o.fire = 1'b1;
        state_d = Idle;
      end
      default: state_d = Idle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
    end
  end

  assign busy_o = (state_q != Idle);

  `TQ_ASSERT_NEXT(a_start_leaves_idle, clk_i, rst_ni, start_i && !busy_o, busy_o,
    "accepted transaction did not raise busy")
  `TQ_ASSERT(a_fire_in_done, clk_i, rst_ni, !cmd_o.fire || state_q == Done,
    "result strobe outside done state")
  `TQ_ASSERT(a_walk_bounded, clk_i, rst_ni, steps_q <= (SlotW+1)'(Capacity),
    "find walk ran past capacity")
endmodule
`default_nettype wire

@@ rtl/tq_dpath.sv @@
// Datapath: node store, links, head, tail, count and result registers
`default_nettype none
`include "thread_queue_with_id_search_defines.svh"
module tq_dpath import tq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [2:0]  op_i,
  input  wire logic [15:0] thread_ref_i,
  input  wire logic [15:0] thread_id_i,
  input  wire logic [3:0]  node_slot_i,
  input  tq_cmd_t          cmd_i,
  output tq_stat_t         stat_o,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      thread_ref_out_o,
  output logic [3:0]       slot_out_o,
  output logic [4:0]       count_o
);
  logic [15:0]       ref_q  [Capacity];
  logic [15:0]       id_q   [Capacity];
  logic [LinkW-1:0]  next_q [Capacity];
  logic [LinkW-1:0]  prev_q [Capacity];
  logic [Capacity-1:0] used_q;
  logic [LinkW-1:0]  head_q, tail_q, cur_q;
  logic [CountW-1:0] cnt_q;
  logic [2:0]        op_q, stat_q;
  logic [15:0]       tref_q, tid_q, rout_q;
  logic [SlotW-1:0]  slot_q, sout_q;
  logic              done_q;
  logic [SlotW-1:0]  free_s, cs, ps, ns;
  logic [LinkW-1:0]  pl, nl;

  // lowest free slot
  always_comb begin
    free_s = '0;
    for (int i = Capacity - 1; i >= 0; i--)
      if (!used_q[i]) free_s = SlotW'(i);
  end

  assign cs = cur_q[SlotW-1:0];
  assign pl = prev_q[cs];
  assign nl = next_q[cs];
  assign ps = pl[SlotW-1:0];
  assign ns = nl[SlotW-1:0];

  assign stat_o.op        = op_q;
  assign stat_o.empty     = head_q[SlotW];
  assign stat_o.full      = &used_q;
  assign stat_o.cur_null  = cur_q[SlotW];
  assign stat_o.id_match  = (id_q[cs] == tid_q);
  assign stat_o.slot_used = used_q[slot_q];

  // node store, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_put) begin
      ref_q[free_s]  <= tref_q;
      id_q[free_s]   <= tid_q;
      next_q[free_s] <= NullLink;
      prev_q[free_s] <= tail_q;
      if (!tail_q[SlotW]) next_q[tail_q[SlotW-1:0]] <= {1'b0, free_s};
    end
    if (cmd_i.do_detach) begin
      if (!pl[SlotW]) next_q[ps] <= nl;
      if (!nl[SlotW]) prev_q[ns] <= pl;
    end
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      head_q <= NullLink;
      tail_q <= NullLink;
      cur_q  <= NullLink;
      cnt_q  <= '0;
      done_q <= 1'b0;
      op_q <= '0; tref_q <= '0; tid_q <= '0; slot_q <= '0;
      stat_q <= StOk; rout_q <= '0; sout_q <= '0;
    end else begin
      done_q <= cmd_i.fire;
      if (cmd_i.latch) begin
        op_q <= op_i; tref_q <= thread_ref_i; tid_q <= thread_id_i;
        slot_q <= node_slot_i;
        rout_q <= '0; sout_q <= '0;
      end
      if (cmd_i.set_stat) stat_q <= cmd_i.status;
      if (cmd_i.load_head) cur_q <= head_q;
      if (cmd_i.cur_unl) cur_q <= {1'b0, slot_q};
      if (cmd_i.step) cur_q <= nl;
      if (cmd_i.hit_save) rout_q <= ref_q[cs];
      if (cmd_i.do_put) begin
        used_q[free_s] <= 1'b1;
        if (tail_q[SlotW]) head_q <= {1'b0, free_s};
        tail_q <= {1'b0, free_s};
        cnt_q  <= cnt_q + 1'b1;
        sout_q <= free_s;
      end
      if (cmd_i.do_detach) begin
        used_q[cs] <= 1'b0;
        if (head_q == cur_q) head_q <= nl;
        if (tail_q == cur_q) tail_q <= pl;
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = stat_q;
  assign thread_ref_out_o = rout_q;
  assign slot_out_o       = sout_q;
  assign count_o          = cnt_q;

  `TQ_ASSERT(a_count_matches, clk_i, rst_ni, cnt_q == CountW'($countones(used_q)),
    "count disagrees with slots in use")
  `TQ_ASSERT(a_empty_consistent, clk_i, rst_ni, head_q[SlotW] == (cnt_q == '0),
    "head null disagrees with count")
  `TQ_ASSERT(a_no_put_when_full, clk_i, rst_ni, !(cmd_i.do_put && (&used_q)),
    "put issued on full store")
endmodule
`default_nettype wire

@@ rtl/thread_queue_with_id_search.sv @@
// Top level: bounded thread queue with search by id
// channel | signals                                    | handshake
// input   | op_i thread_ref_i thread_id_i node_slot_i  | start_i && !busy_o
// result  | status_o thread_ref_out_o slot_out_o count_o | done_o, one cycle
// Put, undefined ops and failed get, peek or unlink go from Decode to Done; get,
// peek and unlink pass through Walk once; find stays in Walk, the find walk
// visiting up to Capacity linked nodes, one linked node per cycle.
// busy_o stays high until the result strobe; the receiver cannot stall.
// Reset is asynchronous: queue empty, no slots in use, no clearing pass.
`default_nettype none
module thread_queue_with_id_search import tq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [15:0] thread_ref_i,
  input  wire logic [15:0] thread_id_i,
  input  wire logic [3:0]  node_slot_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      thread_ref_out_o,
  output logic [3:0]       slot_out_o,
  output logic [4:0]       count_o
);
  tq_cmd_t  cmd;
  tq_stat_t stat;

  tq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .stat_i(stat), .cmd_o(cmd)
  );

  tq_dpath u_dpath (
    .clk_i, .rst_ni, .op_i, .thread_ref_i, .thread_id_i, .node_slot_i,
    .cmd_i(cmd), .stat_o(stat), .done_o, .status_o, .thread_ref_out_o,
    .slot_out_o, .count_o
  );
endmodule
`default_nettype wire
